// File: sv/tcw_pkg.sv
package tcw_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // Field widths of the channels and of one stored entry.
   localparam int STORE_W    = 16;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 4;
   localparam int OP_W       = 2;
   localparam int ROW_PORT_W = 5;
   localparam int COL_PORT_W = 7;
   localparam int CSR_IDX_W  = 1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PRINT      = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;
   localparam logic [OP_W-1:0] OP_READ       = 2'd3;

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BG = 1'd1;

   // Steps of the microprogram.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUT,
      ST_NEWLINE,
      ST_CHECK,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_CLEAR,
      ST_READ,
      ST_BS_MOVE,
      ST_BS_WRITE,
      ST_RESPOND
   } step_type;

   // Source of the data written to the frame store.
   typedef enum logic [2:0] {
      WD_NONE,
      WD_CHAR,
      WD_COPY,
      WD_BLANK,
      WD_FILL
   } wdata_sel_type;

   // Write address source.
   typedef enum logic {
      WA_CURSOR,
      WA_ADDR
   } waddr_sel_type;

   // Read address source.
   typedef enum logic [1:0] {
      RA_NONE,
      RA_ADDR,
      RA_NEXT_ROW
   } raddr_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_DEC
   } cursor_op_type;

   typedef enum logic [1:0] {
      ADDR_HOLD,
      ADDR_INC,
      ADDR_ZERO
   } addr_op_type;

   // Jump conditions.
   typedef enum logic [2:0] {
      C_DISPATCH,
      C_ALWAYS,
      C_MID_ROW,
      C_NO_SCROLL,
      C_COPY_MORE,
      C_FILL_MORE,
      C_OUT_BUSY
   } cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic          take;
      wdata_sel_type wsel;
      waddr_sel_type asel;
      raddr_sel_type rsel;
      cursor_op_type cur_op;
      addr_op_type   addr_op;
      logic          load_rsp;
      cond_type      cond;
      step_type      jump_true;
      step_type      jump_false;
   } ctrl_type;

   // Flags that the datapath returns to the sequencer.
   typedef struct packed {
      logic              accept;
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] ch;
      logic              col_zero;
      logic              read_ok;
      logic              mid_row;
      logic              scroll;
      logic              copy_more;
      logic              fill_more;
      logic              out_busy;
   } status_type;

endpackage

// File: sv/tcw_frame_ram.sv
module tcw_frame_ram #(
   parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [ADDR_W-1:0]          waddr,
   input  logic [tcw_pkg::STORE_W-1:0] wdata,
   input  logic                       re,
   input  logic [ADDR_W-1:0]          raddr,
   output logic [tcw_pkg::STORE_W-1:0] rdata
);

   logic [tcw_pkg::STORE_W-1:0] store_ff [DEPTH];
   logic [tcw_pkg::STORE_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= store_ff[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

// File: sv/tcw_sequencer.sv
module tcw_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::status_type status,
   output tcw_pkg::ctrl_type   ctrl
);

   tcw_pkg::step_type pc_ff;
   tcw_pkg::step_type pc_in;

   // Builds one control word.
   function automatic tcw_pkg::ctrl_type word(
      input logic                   take,
      input tcw_pkg::wdata_sel_type wsel,
      input tcw_pkg::waddr_sel_type asel,
      input tcw_pkg::raddr_sel_type rsel,
      input tcw_pkg::cursor_op_type cur_op,
      input tcw_pkg::addr_op_type   addr_op,
      input logic                   load_rsp,
      input tcw_pkg::cond_type      cond,
      input tcw_pkg::step_type      jt,
      input tcw_pkg::step_type      jf
   );
      tcw_pkg::ctrl_type w;
      w.take       = take;
      w.wsel       = wsel;
      w.asel       = asel;
      w.rsel       = rsel;
      w.cur_op     = cur_op;
      w.addr_op    = addr_op;
      w.load_rsp   = load_rsp;
      w.cond       = cond;
      w.jump_true  = jt;
      w.jump_false = jf;
      return w;
   endfunction

   // The microprogram, one control word per step.
   function automatic tcw_pkg::ctrl_type microcode(input tcw_pkg::step_type s);
      tcw_pkg::ctrl_type w;
      unique case (s)
         tcw_pkg::ST_IDLE: w = word(1'b1, tcw_pkg::WD_NONE, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_DISPATCH, tcw_pkg::ST_IDLE, tcw_pkg::ST_IDLE);
         tcw_pkg::ST_PUT: w = word(1'b0, tcw_pkg::WD_CHAR, tcw_pkg::WA_CURSOR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_INC, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_ALWAYS, tcw_pkg::ST_CHECK, tcw_pkg::ST_CHECK);
         tcw_pkg::ST_NEWLINE: w = word(1'b0, tcw_pkg::WD_CHAR, tcw_pkg::WA_CURSOR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_INC, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_MID_ROW, tcw_pkg::ST_NEWLINE, tcw_pkg::ST_CHECK);
         tcw_pkg::ST_CHECK: w = word(1'b0, tcw_pkg::WD_NONE, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_ZERO, 1'b0,
            tcw_pkg::C_NO_SCROLL, tcw_pkg::ST_RESPOND, tcw_pkg::ST_SCROLL_RD);
         tcw_pkg::ST_SCROLL_RD: w = word(1'b0, tcw_pkg::WD_NONE, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NEXT_ROW, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_ALWAYS, tcw_pkg::ST_SCROLL_WR, tcw_pkg::ST_SCROLL_WR);
         tcw_pkg::ST_SCROLL_WR: w = word(1'b0, tcw_pkg::WD_COPY, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_INC, 1'b0,
            tcw_pkg::C_COPY_MORE, tcw_pkg::ST_SCROLL_RD, tcw_pkg::ST_BLANK);
         tcw_pkg::ST_BLANK: w = word(1'b0, tcw_pkg::WD_BLANK, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_INC, 1'b0,
            tcw_pkg::C_FILL_MORE, tcw_pkg::ST_BLANK, tcw_pkg::ST_RESPOND);
         tcw_pkg::ST_CLEAR: w = word(1'b0, tcw_pkg::WD_FILL, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_INC, 1'b0,
            tcw_pkg::C_FILL_MORE, tcw_pkg::ST_CLEAR, tcw_pkg::ST_RESPOND);
         tcw_pkg::ST_READ: w = word(1'b0, tcw_pkg::WD_NONE, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_ADDR, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_ALWAYS, tcw_pkg::ST_RESPOND, tcw_pkg::ST_RESPOND);
         tcw_pkg::ST_BS_MOVE: w = word(1'b0, tcw_pkg::WD_NONE, tcw_pkg::WA_CURSOR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_DEC, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_ALWAYS, tcw_pkg::ST_BS_WRITE, tcw_pkg::ST_BS_WRITE);
         tcw_pkg::ST_BS_WRITE: w = word(1'b0, tcw_pkg::WD_CHAR, tcw_pkg::WA_CURSOR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_ALWAYS, tcw_pkg::ST_RESPOND, tcw_pkg::ST_RESPOND);
         tcw_pkg::ST_RESPOND: w = word(1'b0, tcw_pkg::WD_NONE, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_HOLD, 1'b1,
            tcw_pkg::C_OUT_BUSY, tcw_pkg::ST_RESPOND, tcw_pkg::ST_IDLE);
         default: w = word(1'b0, tcw_pkg::WD_NONE, tcw_pkg::WA_ADDR,
            tcw_pkg::RA_NONE, tcw_pkg::CUR_HOLD, tcw_pkg::ADDR_HOLD, 1'b0,
            tcw_pkg::C_ALWAYS, tcw_pkg::ST_IDLE, tcw_pkg::ST_IDLE);
      endcase
      return w;
   endfunction

   // Entry step of the routine for a newly accepted transaction.
   function automatic tcw_pkg::step_type dispatch(input tcw_pkg::status_type st);
      tcw_pkg::step_type s;
      unique case (st.op)
         tcw_pkg::OP_PRINT: begin
            if (st.ch == tcw_pkg::CH_NUL) begin
               s = tcw_pkg::ST_RESPOND;
            end else if (st.ch == tcw_pkg::CH_BS) begin
               s = st.col_zero ? tcw_pkg::ST_RESPOND : tcw_pkg::ST_BS_MOVE;
            end else if (st.ch == tcw_pkg::CH_LF) begin
               s = tcw_pkg::ST_NEWLINE;
            end else begin
               s = tcw_pkg::ST_PUT;
            end
         end
         tcw_pkg::OP_SET_CURSOR: s = tcw_pkg::ST_RESPOND;
         tcw_pkg::OP_CLEAR:      s = tcw_pkg::ST_CLEAR;
         tcw_pkg::OP_READ:       s = st.read_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_RESPOND;
         default:                s = tcw_pkg::ST_RESPOND;
      endcase
      return s;
   endfunction

   // Next step: dispatch, or a two-way jump on the selected condition.
   always_comb begin
      pc_in = pc_ff;
      unique case (ctrl.cond)
         tcw_pkg::C_DISPATCH: begin
            if (status.accept) begin
               pc_in = dispatch(status);
            end
         end
         tcw_pkg::C_ALWAYS:    pc_in = ctrl.jump_true;
         tcw_pkg::C_MID_ROW:   pc_in = status.mid_row ? ctrl.jump_true : ctrl.jump_false;
         tcw_pkg::C_NO_SCROLL: pc_in = !status.scroll ? ctrl.jump_true : ctrl.jump_false;
         tcw_pkg::C_COPY_MORE: pc_in = status.copy_more ? ctrl.jump_true : ctrl.jump_false;
         tcw_pkg::C_FILL_MORE: pc_in = status.fill_more ? ctrl.jump_true : ctrl.jump_false;
         tcw_pkg::C_OUT_BUSY:  pc_in = status.out_busy ? ctrl.jump_true : ctrl.jump_false;
         default:              pc_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // Control word of the current step.
   always_comb begin
      ctrl = microcode(pc_ff);
   end

   // After reset the clearing routine sweeps the frame store.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tcw_pkg::ST_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: sv/tcw_datapath.sv
module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF,
   parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input transaction fields
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tcw_pkg::OP_W-1:0]        req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char,
   input  logic [tcw_pkg::ROW_PORT_W-1:0]  req_row,
   input  logic [tcw_pkg::COL_PORT_W-1:0]  req_col,
   input  logic [tcw_pkg::COLOR_W-1:0]     req_clear_bg,
   // Configuration writes
   input  logic                            csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]     csr_wdata,
   // Sequencer
   input  tcw_pkg::ctrl_type               ctrl,
   output tcw_pkg::status_type             status,
   // Frame store
   output logic                            mem_we,
   output logic [ADDR_W-1:0]               mem_waddr,
   output logic [tcw_pkg::STORE_W-1:0]     mem_wdata,
   output logic                            mem_re,
   output logic [ADDR_W-1:0]               mem_raddr,
   input  logic [tcw_pkg::STORE_W-1:0]     mem_rdata,
   // Result transaction fields
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tcw_pkg::ROW_PORT_W-1:0]  rsp_row,
   output logic [tcw_pkg::COL_PORT_W-1:0]  rsp_col,
   output logic [tcw_pkg::STORE_W-1:0]     rsp_value
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   logic [ROW_W-1:0]                 row_ff, row_in;
   logic [COL_W-1:0]                 col_ff, col_in;
   logic                             scroll_ff, scroll_in;
   logic [ADDR_W-1:0]                addr_ff, addr_in;
   logic [tcw_pkg::CHAR_W-1:0]       char_ff, char_in;
   logic [tcw_pkg::COLOR_W-1:0]      clr_bg_ff, clr_bg_in;
   logic [tcw_pkg::COLOR_W-1:0]      fg_ff, fg_in;
   logic [tcw_pkg::COLOR_W-1:0]      bg_ff, bg_in;
   logic                             read_sel_ff, read_sel_in;
   logic                             silent_ff, silent_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::ROW_PORT_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::COL_PORT_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::STORE_W-1:0]      rsp_value_ff, rsp_value_in;

   logic              accept;
   logic              row_ok;
   logic              col_ok;
   logic              col_last;
   logic              row_last;
   logic              out_busy;
   logic              rsp_load;
   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] target_addr;

   // Handshake and flags.
   assign req_tready  = ctrl.take;
   assign accept      = req_tvalid && ctrl.take;
   assign row_ok      = 32'(req_row) < 32'(ROWS);
   assign col_ok      = 32'(req_col) < 32'(COLUMNS);
   assign col_last    = col_ff == COL_W'(COLUMNS - 1);
   assign row_last    = row_ff == ROW_W'(ROWS - 1);
   assign out_busy    = rsp_valid_ff && !rsp_tready;
   assign rsp_load    = ctrl.load_rsp && !out_busy && !silent_ff;

   // Linear addresses of the cursor and of the requested position.
   assign cursor_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign target_addr = ADDR_W'(req_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_col);

   always_comb begin
      status.accept    = accept;
      status.op        = req_opcode;
      status.ch        = req_char;
      status.col_zero  = col_ff == '0;
      status.read_ok   = row_ok && col_ok;
      status.mid_row   = !col_last;
      status.scroll    = scroll_ff;
      status.copy_more = addr_ff != ADDR_W'(CELLS - COLUMNS - 1);
      status.fill_more = addr_ff != ADDR_W'(CELLS - 1);
      status.out_busy  = out_busy;
   end

   // Frame store access driven by the control word.
   always_comb begin
      mem_we = ctrl.wsel != tcw_pkg::WD_NONE;
      unique case (ctrl.wsel)
         tcw_pkg::WD_CHAR:  mem_wdata = {bg_ff, fg_ff, char_ff};
         tcw_pkg::WD_COPY:  mem_wdata = mem_rdata;
         tcw_pkg::WD_BLANK: mem_wdata = {bg_ff, {tcw_pkg::COLOR_W{1'b0}}, tcw_pkg::CH_NUL};
         tcw_pkg::WD_FILL:  mem_wdata = {clr_bg_ff, {tcw_pkg::COLOR_W{1'b0}}, tcw_pkg::CH_NUL};
         default:           mem_wdata = '0;
      endcase
      mem_waddr = (ctrl.asel == tcw_pkg::WA_CURSOR) ? cursor_addr : addr_ff;
      mem_re    = ctrl.rsel != tcw_pkg::RA_NONE;
      mem_raddr = (ctrl.rsel == tcw_pkg::RA_NEXT_ROW) ? addr_ff + ADDR_W'(COLUMNS) : addr_ff;
   end

   // Next values of the working registers.
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      scroll_in    = scroll_ff;
      addr_in      = addr_ff;
      char_in      = char_ff;
      clr_bg_in    = clr_bg_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      read_sel_in  = read_sel_ff;
      silent_in    = silent_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;

      // Cursor movement; a wrap off the last row flags a scroll.
      unique case (ctrl.cur_op)
         tcw_pkg::CUR_INC: begin
            if (col_last) begin
               col_in    = '0;
               scroll_in = row_last;
               if (!row_last) begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in    = col_ff + COL_W'(1);
               scroll_in = 1'b0;
            end
         end
         tcw_pkg::CUR_DEC: col_in = col_ff - COL_W'(1);
         default: ;
      endcase

      // Sweep address.
      unique case (ctrl.addr_op)
         tcw_pkg::ADDR_INC:  addr_in = addr_ff + ADDR_W'(1);
         tcw_pkg::ADDR_ZERO: addr_in = '0;
         default: ;
      endcase

      // Capture of a new transaction.
      if (accept) begin
         silent_in   = 1'b0;
         read_sel_in = (req_opcode == tcw_pkg::OP_READ) && row_ok && col_ok;
         if (req_char == tcw_pkg::CH_LF) begin
            char_in = tcw_pkg::CH_SPACE;
         end else if (req_char == tcw_pkg::CH_BS) begin
            char_in = tcw_pkg::CH_NUL;
         end else begin
            char_in = req_char;
         end
         unique case (req_opcode)
            tcw_pkg::OP_SET_CURSOR: begin
               row_in = row_ok ? ROW_W'(req_row) : ROW_W'(ROWS - 1);
               col_in = col_ok ? COL_W'(req_col) : COL_W'(COLUMNS - 1);
            end
            tcw_pkg::OP_CLEAR: begin
               row_in    = '0;
               col_in    = '0;
               addr_in   = '0;
               clr_bg_in = req_clear_bg;
            end
            tcw_pkg::OP_READ: addr_in = target_addr;
            default: ;
         endcase
      end

      // Colour registers.
      if (csr_we) begin
         unique case (csr_index)
            tcw_pkg::REG_FG: fg_in = csr_wdata;
            tcw_pkg::REG_BG: bg_in = csr_wdata;
            default: ;
         endcase
      end

      // Output register: it frees the sequencer while a result waits.
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = tcw_pkg::ROW_PORT_W'(row_ff);
         rsp_col_in   = tcw_pkg::COL_PORT_W'(col_ff);
         rsp_value_in = read_sel_ff ? mem_rdata : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state; the sweep address and fill colour also take part in the reset clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         scroll_ff    <= 1'b0;
         addr_ff      <= '0;
         clr_bg_ff    <= '0;
         fg_ff        <= '0;
         bg_ff        <= '0;
         read_sel_ff  <= 1'b0;
         silent_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         scroll_ff    <= scroll_in;
         addr_ff      <= addr_in;
         clr_bg_ff    <= clr_bg_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         read_sel_ff  <= read_sel_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

// File: sv/text_console_writer_top.sv
// A printed character is written at the cursor, the cursor advances and a scroll check follows.
// A newline writes spaces to the row end, a backspace steps back and writes NUL, a read fetches
// one entry; set cursor, NUL and an out-of-range read go straight to the result. A scroll copies
// each entry up a row by a read and a write step and then blanks the last row. Blanking and a
// clear write one entry per cycle. The result is registered and shows in the same cycle as the
// next input can be accepted. Reset is synchronous; a clearing pass then zeroes the store.
module text_console_writer_top #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // opcode[1:0], char_code[9:2], target_row[14:10], target_col[21:15], clear_bg[25:22]
   input  logic [31:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // cursor_row[4:0], cursor_col[11:5], cell_value[27:12]
   output logic [31:0]                   rsp_tdata,
   input  logic                          csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_wdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   tcw_pkg::ctrl_type   ctrl;
   tcw_pkg::status_type status;

   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_waddr;
   logic [tcw_pkg::STORE_W-1:0]    mem_wdata;
   logic                           mem_re;
   logic [ADDR_W-1:0]              mem_raddr;
   logic [tcw_pkg::STORE_W-1:0]    mem_rdata;
   logic [tcw_pkg::ROW_PORT_W-1:0] rsp_row;
   logic [tcw_pkg::COL_PORT_W-1:0] rsp_col;
   logic [tcw_pkg::STORE_W-1:0]    rsp_value;

   tcw_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .ADDR_W  (ADDR_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_opcode   (req_tdata[1:0]),
      .req_char     (req_tdata[9:2]),
      .req_row      (req_tdata[14:10]),
      .req_col      (req_tdata[21:15]),
      .req_clear_bg (req_tdata[25:22]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ctrl         (ctrl),
      .status       (status),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_row      (rsp_row),
      .rsp_col      (rsp_col),
      .rsp_value    (rsp_value)
   );

   tcw_frame_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_frame_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Result fields packed from the lowest bit up, padded to whole bytes.
   assign rsp_tdata = {4'b0000, rsp_value, rsp_col, rsp_row};

`ifndef ASSERT_OFF
   // Only one transaction is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a transaction was still in work");

   // The clearing pass holds off input once reset is released.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("input offered before the frame store was cleared");

   // The frame store is never written in the cycle a transaction is taken.
   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !mem_we)
      else $error("frame store written while idle");

   // Reported cursor always lies on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[4:0]) < 32'(ROWS)) && (32'(rsp_tdata[11:5]) < 32'(COLUMNS)))
      else $error("cursor outside the screen");
`endif

endmodule

// File: sim/tcw_checker.sv
module tcw_checker
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [31:0]          req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [31:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS   = COLUMNS_DEF;
   localparam int ROWS_N = ROWS_DEF;
   localparam int CELLS  = COLS * ROWS_N;

   typedef struct packed {
      logic [ROW_PORT_W-1:0] row;
      logic [COL_PORT_W-1:0] col;
      logic [STORE_W-1:0]    cell_val;
   } console_result_type;

   // Shadow copy of the screen, the cursor and the colour registers.
   logic [STORE_W-1:0] screen_mem [CELLS];
   int unsigned        cur_row;
   int unsigned        cur_col;
   logic [COLOR_W-1:0] fg_reg;
   logic [COLOR_W-1:0] bg_reg;

   console_result_type expected_results [$];

   // Writes one glyph at the cursor and advances it, wrapping at the row end and
   // scrolling the whole screen up by one row when the last row overflows.
   function automatic void put_glyph(input logic [CHAR_W-1:0] ch);
      screen_mem[cur_row * COLS + cur_col] = {bg_reg, fg_reg, ch};
      if (cur_col == COLS - 1) begin
         cur_col = 0;
         if (cur_row == ROWS_N - 1) begin
            for (int i = 0; i < CELLS - COLS; i++)
               screen_mem[i] = screen_mem[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
               screen_mem[i] = {bg_reg, {COLOR_W{1'b0}}, CH_NUL};
         end else begin
            cur_row++;
         end
      end else begin
         cur_col++;
      end
   endfunction

   // Carries out one console command on the shadow state and returns the result it causes.
   function automatic console_result_type apply_console_op(input logic [31:0] d);
      logic [OP_W-1:0]       op;
      logic [CHAR_W-1:0]     ch;
      logic [ROW_PORT_W-1:0] row;
      logic [COL_PORT_W-1:0] col;
      logic [COLOR_W-1:0]    cbg;
      int unsigned           pad;
      console_result_type    res;
      op           = d[1:0];
      ch           = d[9:2];
      row          = d[14:10];
      col          = d[21:15];
      cbg          = d[25:22];
      res.cell_val = '0;
      case (op)
         OP_PRINT: begin
            if (ch == CH_BS) begin
               // Backspace at column zero leaves everything as it is.
               if (cur_col != 0) begin
                  cur_col--;
                  screen_mem[cur_row * COLS + cur_col] = {bg_reg, fg_reg, CH_NUL};
               end
            end else if (ch == CH_LF) begin
               pad = COLS - cur_col;
               repeat (pad) put_glyph(CH_SPACE);
            end else if (ch != CH_NUL) begin
               put_glyph(ch);
            end
         end
         OP_SET_CURSOR: begin
            cur_row = (row < ROWS_N) ? row : ROWS_N - 1;
            cur_col = (col < COLS) ? col : COLS - 1;
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_mem[i] = {cbg, {COLOR_W{1'b0}}, CH_NUL};
            cur_row = 0;
            cur_col = 0;
         end
         default: begin
            if (row < ROWS_N && col < COLS)
               res.cell_val = screen_mem[row * COLS + col];
         end
      endcase
      res.row = ROW_PORT_W'(cur_row);
      res.col = COL_PORT_W'(cur_col);
      return res;
   endfunction

   // Watch both channels and the register port; predict on each input transaction and
   // compare each result transaction with the oldest prediction.
   always @(posedge clock) begin : monitor
      console_result_type exp_r;
      console_result_type got_r;
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen_mem[i] = '0;
         cur_row    = 0;
         cur_col    = 0;
         fg_reg     = '0;
         bg_reg     = '0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FG:  fg_reg = csr_wdata;
               REG_BG:  bg_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_console_op(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got_r.row      = rsp_tdata[4:0];
            got_r.col      = rsp_tdata[11:5];
            got_r.cell_val = rsp_tdata[27:12];
            if (expected_results.size() == 0) begin
               $display("%0t: result with none expected: row %0d col %0d cell %h",
                        $time, got_r.row, got_r.col, got_r.cell_val);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (got_r.row !== exp_r.row || got_r.col !== exp_r.col ||
                   got_r.cell_val !== exp_r.cell_val) begin
                  $display("%0t: mismatch: expected row %0d col %0d cell %h, got row %0d col %0d cell %h",
                           $time, exp_r.row, exp_r.col, exp_r.cell_val,
                           got_r.row, got_r.col, got_r.cell_val);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: sim/tb.sv
module tb;
   import tcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS  = 650;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 50;
   localparam int LIMIT_CYCLES = 50_000_000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COLOR_W-1:0]   csr_wdata;

   int fail_count;
   int pending;
   int items_sent;
   int send_idle_pct;
   int rcv_idle_pct;
   int cycle_count;

   text_console_writer_top #(
      .COLUMNS(COLUMNS_DEF),
      .ROWS   (ROWS_DEF)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tcw_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the run hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus two long hold-offs so that the block backs up.
   initial begin : result_sink
      int hold_left;
      int held_at;
      hold_left  = 0;
      held_at    = -1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if ((items_sent == 300 || items_sent == 1500) && items_sent != held_at) begin
            held_at   = items_sent;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   function automatic logic [31:0] pack_req(input logic [OP_W-1:0] op,
                                            input logic [CHAR_W-1:0] ch,
                                            input logic [ROW_PORT_W-1:0] row,
                                            input logic [COL_PORT_W-1:0] col,
                                            input logic [COLOR_W-1:0] cbg);
      return {6'b0, cbg, col, row, ch, op};
   endfunction

   // Random command: mostly printing, with cursor moves, reads biased on screen
   // and occasional clears; control characters are drawn more often than chance.
   function automatic logic [31:0] random_command();
      logic [OP_W-1:0]       op;
      logic [CHAR_W-1:0]     ch;
      logic [ROW_PORT_W-1:0] row;
      logic [COL_PORT_W-1:0] col;
      logic [COLOR_W-1:0]    cbg;
      int unsigned           pick;
      ch   = CHAR_W'($urandom_range(255));
      row  = ROW_PORT_W'($urandom_range(31));
      col  = COL_PORT_W'($urandom_range(127));
      cbg  = COLOR_W'($urandom_range(15));
      pick = $urandom_range(999);
      if (pick < 6) begin
         op = OP_CLEAR;
      end else if (pick < 130) begin
         op = OP_SET_CURSOR;
      end else if (pick < 380) begin
         op = OP_READ;
         if ($urandom_range(9) < 7) begin
            row = ROW_PORT_W'($urandom_range(ROWS_DEF - 1));
            col = COL_PORT_W'($urandom_range(COLUMNS_DEF - 1));
         end
      end else begin
         op   = OP_PRINT;
         pick = $urandom_range(99);
         if (pick < 3)
            ch = CH_LF;
         else if (pick < 8)
            ch = CH_BS;
         else if (pick < 11)
            ch = CH_NUL;
      end
      return pack_req(op, ch, row, col, cbg);
   endfunction

   // Offer one transaction after a random idle gap; returns at the falling edge after
   // it has been taken.
   task automatic send_item(input logic [31:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Colours may only change while the block is idle.
   task automatic set_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      drain_results();
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_FG;
      csr_wdata <= fg;
      @(negedge clock);
      csr_index <= REG_BG;
      csr_wdata <= bg;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_index     = REG_FG;
      csr_wdata     = '0;
      items_sent    = 0;
      send_idle_pct = 22;
      rcv_idle_pct  = 71;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its store after reset before it takes anything.
      while (!req_tready) @(negedge clock);
      set_colours(4'hF, 4'h0);

      // Directed commands: extremes, control characters, wrap with scroll, range limits.
      send_item(pack_req(OP_READ, 8'h00, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_PRINT, 8'd65, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_PRINT, CH_NUL, 5'd31, 7'd127, 4'hF));
      send_item(pack_req(OP_PRINT, 8'hFF, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_READ, 8'hFF, 5'd0, 7'd1, 4'hF));
      send_item(pack_req(OP_PRINT, CH_BS, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_READ, 8'h00, 5'd0, 7'd1, 4'h0));
      send_item(pack_req(OP_SET_CURSOR, 8'h00, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_PRINT, CH_BS, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_SET_CURSOR, 8'hFF, 5'd31, 7'd127, 4'hF));
      send_item(pack_req(OP_PRINT, 8'd90, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_READ, 8'h00, 5'd23, 7'd79, 4'h0));
      send_item(pack_req(OP_READ, 8'h00, 5'd24, 7'd5, 4'h0));
      send_item(pack_req(OP_READ, 8'h00, 5'd31, 7'd127, 4'h0));
      send_item(pack_req(OP_READ, 8'h00, 5'd25, 7'd0, 4'h0));
      send_item(pack_req(OP_READ, 8'h00, 5'd0, 7'd80, 4'h0));
      send_item(pack_req(OP_SET_CURSOR, 8'h00, 5'd24, 7'd70, 4'h0));
      send_item(pack_req(OP_PRINT, CH_LF, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_SET_CURSOR, 8'h00, 5'd3, 7'd10, 4'h0));
      send_item(pack_req(OP_PRINT, CH_LF, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_PRINT, 8'h80, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_CLEAR, 8'h00, 5'd0, 7'd0, 4'hF));
      send_item(pack_req(OP_READ, 8'h00, 5'd24, 7'd79, 4'h0));
      send_item(pack_req(OP_CLEAR, 8'h00, 5'd0, 7'd0, 4'h0));
      send_item(pack_req(OP_READ, 8'h00, 5'd0, 7'd0, 4'h0));

      // Random phases with different colours and different idling on each side.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: set_colours(4'h0, 4'hF);
            1: set_colours(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
            default: set_colours(4'hF, 4'hF);
         endcase
         send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 71 : 0;
         rcv_idle_pct  = (phase == 0) ? 71 : (phase == 1) ? 22 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 100)
               drain_results();
            send_item(random_command());
         end
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: text_console_writer_top.f
sv/tcw_pkg.sv
sv/tcw_frame_ram.sv
sv/tcw_sequencer.sv
sv/tcw_datapath.sv
sv/text_console_writer_top.sv
sim/tcw_checker.sv
sim/tb.sv
